// File: hw/rtl/bff_pkg.sv
`timescale 1ns / 1ps

package bff_pkg;

    localparam logic [31:0] FNV_PRIME   = 32'd16777619;
    localparam logic [31:0] FNV_BASIS   = 32'd2166136261;
    localparam int          ROT_RIGHT   = 17;
    localparam int          ROT_LEFT    = 15;
    localparam logic [4:0]  PROBE_LIMIT = 5'd30;
    localparam int          HASH_W      = 32;
    localparam logic [5:0]  DIV_STEPS   = 6'd32;

    localparam logic REG_FILTER_BITS = 1'b0;
    localparam logic REG_HASH_COUNT  = 1'b1;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_QUERY  = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_START,
        ST_DIV,
        ST_READ,
        ST_CHECK,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic fold;        // fold the accepted byte into the running hash
        logic key_load;    // last byte: capture probe hash, delta and kind
        logic clear_start; // restart hash and the clearing sweep
        logic clear_step;  // zero one row of the bit store
        logic div_start;   // start the remainder unit on the probe hash
        logic mem_rd;      // read the row of the current probe
        logic probe_wr;    // write the probed row back with the bit set
        logic advance;     // step to the next probe
    } cmd_t;

    typedef struct packed {
        logic n_zero;      // effective filter size is zero
        logic left_zero;   // no probes left
        logic div_done;    // remainder unit idle, result valid
        logic bit_set;     // probed bit is set
        logic clr_last;    // clearing sweep is at its last row
        logic is_query;    // current key ends in a query
    } sts_t;

    // Multiply by the FNV prime, 2^24 + 403, as shifts and adds.
    function automatic logic [31:0] fnv_mult(input logic [31:0] x);
        fnv_mult = (x << 24) + (x << 8) + (x << 7) + (x << 4) + (x << 1) + x;
    endfunction

endpackage

// File: hw/rtl/bff_ctrl.sv
`timescale 1ns / 1ps

module bff_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [1:0]        in_op,
    input  logic              in_last,
    output logic              in_ready,
    output logic              out_valid,
    output logic              out_bit,
    input  logic              out_ready,
    input  bff_pkg::sts_t     sts,
    output bff_pkg::cmd_t     cmd
);

    bff_pkg::state_t state_reg, state_next;
    logic ans_reg, ans_next;
    logic out_valid_reg, out_valid_next;
    logic out_bit_reg, out_bit_next;
    logic accept;
    logic key_op;

    assign accept = in_valid && in_ready;
    assign key_op = (in_op == bff_pkg::OP_INSERT) || (in_op == bff_pkg::OP_QUERY);

    always_comb
    begin
        state_next = state_reg;
        ans_next   = ans_reg;
        unique case (state_reg)
            bff_pkg::ST_CLEAR:
            begin
                if (sts.clr_last)
                    state_next = bff_pkg::ST_IDLE;
            end
            bff_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_op == bff_pkg::OP_CLEAR)
                        state_next = bff_pkg::ST_CLEAR;
                    else if (key_op && in_last)
                        state_next = bff_pkg::ST_START;
                end
            end
            bff_pkg::ST_START:
            begin
                ans_next = 1'b1;
                if (sts.n_zero || sts.left_zero)
                    state_next = bff_pkg::ST_FINISH;
                else
                    state_next = bff_pkg::ST_DIV;
            end
            bff_pkg::ST_DIV:
            begin
                if (sts.div_done)
                    state_next = bff_pkg::ST_READ;
            end
            bff_pkg::ST_READ:
            begin
                state_next = bff_pkg::ST_CHECK;
            end
            bff_pkg::ST_CHECK:
            begin
                if (sts.is_query && !sts.bit_set)
                begin
                    ans_next   = 1'b0;
                    state_next = bff_pkg::ST_FINISH;
                end
                else
                begin
                    // Back to START, which ends the key when the probe just made was the last one.
                    state_next = bff_pkg::ST_START;
                end
            end
            bff_pkg::ST_FINISH:
            begin
                if (!sts.is_query || !out_valid_reg || out_ready)
                    state_next = bff_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = bff_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd            = '0;
        in_ready       = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        out_bit_next   = out_bit_reg;
        unique case (state_reg)
            bff_pkg::ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
            end
            bff_pkg::ST_IDLE:
            begin
                in_ready        = 1'b1;
                cmd.fold        = accept && key_op && !in_last;
                cmd.key_load    = accept && key_op && in_last;
                cmd.clear_start = accept && (in_op == bff_pkg::OP_CLEAR);
            end
            bff_pkg::ST_START:
            begin
                cmd.div_start = !(sts.n_zero || sts.left_zero);
            end
            bff_pkg::ST_DIV:
            begin
                cmd.mem_rd = sts.div_done;
            end
            bff_pkg::ST_READ:
            begin
            end
            bff_pkg::ST_CHECK:
            begin
                cmd.probe_wr = !sts.is_query;
                cmd.advance  = !(sts.is_query && !sts.bit_set);
            end
            bff_pkg::ST_FINISH:
            begin
                if (sts.is_query && (!out_valid_reg || out_ready))
                begin
                    out_valid_next = 1'b1;
                    out_bit_next   = ans_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bff_pkg::ST_CLEAR;
            ans_reg       <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ans_reg       <= ans_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_bit_reg <= out_bit_next;
    end

    assign out_valid = out_valid_reg;
    assign out_bit   = out_bit_reg;

endmodule

// File: hw/rtl/bff_datapath.sv
`timescale 1ns / 1ps

module bff_datapath
#(
    parameter int MAX_BITS = 8192
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic          cfg_addr,
    input  logic [13:0]   cfg_wdata,
    input  logic [1:0]    in_op,
    input  logic [7:0]    in_byte,
    input  bff_pkg::cmd_t cmd,
    output bff_pkg::sts_t sts
);

    localparam int ROWS = MAX_BITS / 8;
    localparam int AW   = $clog2(ROWS);
    localparam int NW   = $clog2(MAX_BITS + 1);
    localparam logic [31:0] USABLE = 32'(ROWS * 8);

    logic [13:0] filter_bits_reg;
    logic [4:0]  hash_count_reg;
    logic [31:0] hash_reg, hash_next;
    logic [31:0] probe_h_reg, probe_h_next;
    logic [31:0] delta_reg, delta_next;
    logic        query_reg, query_next;
    logic [4:0]  left_reg, left_next;
    logic [31:0] dvd_reg, dvd_next;
    logic [NW-1:0] rem_reg, rem_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic [7:0]  rd_data_reg;
    logic [7:0]  mem [ROWS];

    logic [31:0] folded;
    logic [31:0] fb32;
    logic [31:0] n32;
    logic [NW-1:0] n_eff;
    logic [4:0]  probes;
    logic [NW:0] trial;
    logic        wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]  wr_data;
    logic [AW-1:0] row;

    assign folded = bff_pkg::fnv_mult(hash_reg ^ {24'd0, in_byte});
    assign fb32   = {18'd0, filter_bits_reg & 14'h3FF8};
    assign n32    = (fb32 > USABLE) ? USABLE : fb32;
    assign n_eff  = n32[NW-1:0];
    assign probes = (hash_count_reg > bff_pkg::PROBE_LIMIT) ? bff_pkg::PROBE_LIMIT
                                                           : hash_count_reg;
    assign trial  = {rem_reg, dvd_reg[31]};
    assign row    = rem_reg[AW+2:3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_bits_reg <= 14'd8192;
            hash_count_reg  <= 5'd6;
        end
        else if (cfg_we)
        begin
            if (cfg_addr == bff_pkg::REG_FILTER_BITS)
                filter_bits_reg <= cfg_wdata;
            else
                hash_count_reg <= cfg_wdata[4:0];
        end
    end

    always_comb
    begin
        hash_next    = hash_reg;
        probe_h_next = probe_h_reg;
        delta_next   = delta_reg;
        query_next   = query_reg;
        left_next    = left_reg;
        dvd_next     = dvd_reg;
        rem_next     = rem_reg;
        cnt_next     = cnt_reg;
        clr_next     = clr_reg;
        if (cmd.fold)
            hash_next = folded;
        if (cmd.key_load)
        begin
            hash_next    = bff_pkg::FNV_BASIS;
            probe_h_next = folded;
            delta_next   = (folded >> bff_pkg::ROT_RIGHT) | (folded << bff_pkg::ROT_LEFT);
            query_next   = (in_op == bff_pkg::OP_QUERY);
            left_next    = probes;
        end
        if (cmd.clear_start)
        begin
            hash_next = bff_pkg::FNV_BASIS;
            clr_next  = '0;
        end
        if (cmd.clear_step)
            clr_next = clr_reg + AW'(1);
        if (cmd.advance)
        begin
            probe_h_next = probe_h_reg + delta_reg;
            left_next    = left_reg - 5'd1;
        end
        if (cmd.div_start)
        begin
            dvd_next = probe_h_reg;
            rem_next = '0;
            cnt_next = bff_pkg::DIV_STEPS;
        end
        else if (cnt_reg != 6'd0)
        begin
            // One restoring remainder step per cycle.
            dvd_next = {dvd_reg[30:0], 1'b0};
            if (trial >= {1'b0, n_eff})
                rem_next = NW'(trial - {1'b0, n_eff});
            else
                rem_next = trial[NW-1:0];
            cnt_next = cnt_reg - 6'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg <= bff_pkg::FNV_BASIS;
            cnt_reg  <= '0;
            clr_reg  <= '0;
            left_reg <= '0;
        end
        else
        begin
            hash_reg <= hash_next;
            cnt_reg  <= cnt_next;
            clr_reg  <= clr_next;
            left_reg <= left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        probe_h_reg <= probe_h_next;
        delta_reg   <= delta_next;
        query_reg   <= query_next;
        dvd_reg     <= dvd_next;
        rem_reg     <= rem_next;
    end

    assign wr_en   = cmd.clear_step || cmd.probe_wr;
    assign wr_addr = cmd.clear_step ? clr_reg : row;
    assign wr_data = cmd.clear_step ? 8'd0 : (rd_data_reg | (8'd1 << rem_reg[2:0]));

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (cmd.mem_rd)
            rd_data_reg <= mem[row];
    end

    assign sts.n_zero    = (n_eff == '0);
    assign sts.left_zero = (left_reg == 5'd0);
    assign sts.div_done  = (cnt_reg == 6'd0);
    assign sts.bit_set   = rd_data_reg[rem_reg[2:0]];
    assign sts.clr_last  = (clr_reg == AW'(ROWS - 1));
    assign sts.is_query  = query_reg;

endmodule

// File: hw/rtl/bloom_filter_fnv1a.sv
`timescale 1ns / 1ps

// Bloom filter engine keyed by a 32-bit FNV-1a hash with double hashing.
// The slave channel takes one item per key byte: tdata is the byte, tuser the
// operation (insert, query, clear) and tlast marks the final byte of a key.
// Non-final bytes are taken one per cycle. On a final byte the block runs the
// probe sequence and drops tready until it is done. Each probe runs the
// radix-2 remainder unit over the 32 hash bits and reads the row at its end,
// then takes the read data, checks or writes back the bit and starts the next
// probe, all with tready low; a query may end early at the first clear bit.
// A query key end gives one result item on the master channel, bit 0 of
// tdata, set from the finish state, reached via the start state after the
// last probe check or directly on an early miss. It sits in an output
// register; when the receiver stalls, the engine still takes new bytes and
// only waits at the end of the next query if the old result is not taken.
// A clear item, and reset, run a sweep that zeroes the bit store one byte
// row per cycle over MAX_BITS / 8 rows (1024 by default), with tready low.
// The configuration port writes filter_bits (index 0) and hash_count
// (index 1); write it only while the engine is idle.

module bloom_filter_fnv1a
#(
    parameter int MAX_BITS = 8192
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [13:0] cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] key_byte
    input  logic [1:0]  s_axis_tuser,   // [1:0] operation
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata    // [0] may_contain, [7:1] zero
);

    bff_pkg::cmd_t cmd;
    bff_pkg::sts_t sts;
    logic          out_bit;

    bff_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_op     (s_axis_tuser),
        .in_last   (s_axis_tlast),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_bit   (out_bit),
        .out_ready (m_axis_tready),
        .sts       (sts),
        .cmd       (cmd)
    );

    bff_datapath #(.MAX_BITS(MAX_BITS)) u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .in_op     (s_axis_tuser),
        .in_byte   (s_axis_tdata),
        .cmd       (cmd),
        .sts       (sts)
    );

    assign m_axis_tdata = {7'd0, out_bit};

`ifndef ASSERT_OFF
    // A row is read only once the remainder unit has finished.
    a_read_after_div: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mem_rd |-> sts.div_done)
        else $error("row read while remainder unit busy");

    // A probe write-back always follows the read of its row.
    a_write_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.probe_wr |-> $past(cmd.mem_rd, 2))
        else $error("probe write without a preceding row read");

    // No byte is taken while the remainder unit runs.
    a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
        !sts.div_done |-> !s_axis_tready)
        else $error("input taken during remainder computation");

    // A clear item starts the sweep, which holds off input.
    a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser == bff_pkg::OP_CLEAR)
            |=> !s_axis_tready)
        else $error("input taken right after a clear");
`endif

endmodule
